### hdl/ivc_pkg.sv
// Package for the inversion counter: sizes, saturation limit and the token
// that travels down the cell chain. No dependencies.
`default_nettype none
package ivc_pkg;
  localparam int MAX_LEN    = 256;
  localparam int VALUE_BITS = 32;
  localparam int IN_BITS    = 32;
  localparam int CNT_W      = $clog2(MAX_LEN);
  localparam int STORED_W   = $clog2(MAX_LEN + 1);
  localparam int TOTAL_W    = 15;
  localparam int COUNT_W    = 9;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // One element in flight: compare count so far and whether it found a home.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             stored;
    value_t           value;
    logic [CNT_W-1:0] cnt;
  } token_t;

  // Trim or sign-extend the 32-bit input to the stored key width.
  function automatic value_t to_key(input logic signed [IN_BITS-1:0] v);
    logic signed [IN_BITS+VALUE_BITS-1:0] ext;
    ext = {{VALUE_BITS{v[IN_BITS-1]}}, v};
    return ext[VALUE_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

### hdl/ivc_in_if.sv
// Input channel of the inversion counter: one sequence element per beat.
// Depends on ivc_pkg.
`default_nettype none
interface ivc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ivc_pkg::IN_BITS-1:0] value;
  logic                        last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

### hdl/ivc_out_if.sv
// Result channel of the inversion counter: one summary beat per sequence.
// Depends on ivc_pkg.
`default_nettype none
interface ivc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ivc_pkg::TOTAL_W-1:0]   inversions;
  logic [ivc_pkg::COUNT_W-1:0]   element_count;
  logic                          overflow;

  modport source (output valid, output inversions, output element_count,
                  output overflow, input ready);
  modport sink   (input valid, input inversions, input element_count,
                  input overflow, output ready);
endinterface
`default_nettype wire

### hdl/ivc_cell.sv
// One storage cell: holds one element, counts smaller passing tokens, and
// forwards the token one cell per cycle while adv is set. Uses ivc_pkg.
`default_nettype none
module ivc_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire ivc_pkg::token_t tok_i,
  output ivc_pkg::token_t      tok_o
);
  ivc_pkg::token_t tok_r, tok_nxt;
  ivc_pkg::value_t val_r, val_nxt;
  logic            full_r, full_nxt;
  logic            hit, place;

  always_comb begin
    hit   = tok_i.valid & full_r & (val_r > tok_i.value);
    // first empty cell takes the element
    place = tok_i.valid & ~full_r & ~tok_i.stored;

    tok_nxt        = tok_i;
    tok_nxt.cnt    = tok_i.cnt + ivc_pkg::CNT_W'(hit);
    tok_nxt.stored = tok_i.stored | place;

    full_nxt = full_r;
    val_nxt  = val_r;
    if (tok_i.valid && tok_i.last) begin
      // closing element wipes the cell; the next sequence follows behind it
      full_nxt = 1'b0;
    end else if (place) begin
      full_nxt = 1'b1;
      val_nxt  = tok_i.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      full_r <= 1'b0;
    end else if (adv) begin
      tok_r  <= tok_nxt;
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= val_nxt;
    end
  end

  assign tok_o = tok_r;
endmodule
`default_nettype wire

### hdl/ivc_tail.sv
// End of the chain: accumulates per-element counts into the sequence total
// and holds the result beat until taken. Uses ivc_pkg and ivc_out_if.
`default_nettype none
module ivc_tail (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ivc_pkg::token_t tok_i,
  output logic                 adv,
  ivc_out_if.source            out_bus
);
  logic [ivc_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [ivc_pkg::STORED_W-1:0] count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ivc_pkg::TOTAL_W-1:0]  out_inv_r, out_inv_nxt;
  logic [ivc_pkg::COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic [ivc_pkg::TOTAL_W:0]    sum;
  logic                         take;

  assign adv  = ~out_valid_r | out_bus.ready;
  assign take = adv & tok_i.valid;
  assign sum  = {1'b0, total_r} + (ivc_pkg::TOTAL_W + 1)'(tok_i.cnt);

  always_comb begin
    total_nxt     = total_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & ~out_bus.ready;
    out_inv_nxt   = out_inv_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    if (take) begin
      if (tok_i.stored) begin
        total_nxt = sum[ivc_pkg::TOTAL_W] ? ivc_pkg::TOTAL_MAX
                                          : sum[ivc_pkg::TOTAL_W-1:0];
        count_nxt = count_r + ivc_pkg::STORED_W'(1);
      end else begin
        // no free cell: element dropped, sequence flagged
        ovf_nxt = 1'b1;
      end
      if (tok_i.last) begin
        out_valid_nxt = 1'b1;
        out_inv_nxt   = total_nxt;
        out_cnt_nxt   = ivc_pkg::COUNT_W'(count_nxt);
        out_ovf_nxt   = ovf_nxt;
        total_nxt     = '0;
        count_nxt     = '0;
        ovf_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_inv_r <= out_inv_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.inversions    = out_inv_r;
  assign out_bus.element_count = out_cnt_r;
  assign out_bus.overflow      = out_ovf_r;
endmodule
`default_nettype wire

### hdl/inversion_counter_unit.sv
// Inversion counter top level: entry logic, chain of MAX_LEN cells, tail.
// Uses ivc_pkg, ivc_in_if, ivc_out_if, ivc_cell and ivc_tail.
//
// Usage: stream a sequence on in_bus, one signed 32-bit element per beat,
// with last set on the final beat. For each sequence one beat appears on
// out_bus: inversions (pairs i<j with element i > element j), the number
// of elements stored and an overflow flag if the sequence ran past MAX_LEN
// elements (extra elements are dropped and not counted).
// Throughput: one element per cycle, sequences back to back with no gap.
// Each element walks the chain one cell per cycle, comparing itself with
// every stored element and settling into the first empty cell.
// The last beat passes through the MAX_LEN cell registers and then the
// tail's result register. The final element clears the cells as it
// passes, so the next sequence may follow immediately.
// Reset (synchronous, active low) empties all cells and drops any work in
// flight. When out_bus is stalled with a result pending, the whole chain
// freezes and in_bus.ready falls until the result is taken.
`default_nettype none
module inversion_counter_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ivc_in_if.sink    in_bus,
  ivc_out_if.source out_bus
);
  ivc_pkg::token_t tok [0:ivc_pkg::MAX_LEN];
  logic            adv;

  assign in_bus.ready = adv;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = in_bus.valid & adv;
    tok[0].last   = in_bus.last;
    tok[0].value  = ivc_pkg::to_key(in_bus.value);
  end

  for (genvar k = 0; k < ivc_pkg::MAX_LEN; k++) begin : g_cell
    ivc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
  end

  ivc_tail u_tail (
    .clk     (clk),
    .rst_n   (rst_n),
    .tok_i   (tok[ivc_pkg::MAX_LEN]),
    .adv     (adv),
    .out_bus (out_bus)
  );
endmodule
`default_nettype wire

### hdl/ivc_checker.sv
// Port-level checks for the inversion counter, bound to the top level.
// Uses ivc_pkg.
`default_nettype none
module ivc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ivc_pkg::TOTAL_W-1:0] out_inversions,
  input wire logic [ivc_pkg::COUNT_W-1:0] out_element_count,
  input wire logic                        out_overflow
);
  // input is held off exactly while a result beat is stuck
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in ready does not track output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inversions)
      && $stable(out_element_count) && $stable(out_overflow))
    else $error("result beat changed while stalled");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_element_count == ivc_pkg::COUNT_W'(ivc_pkg::MAX_LEN))
    else $error("overflow without a full chain");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_element_count != '0)
    else $error("result with no stored element");
endmodule

bind inversion_counter_unit ivc_checker u_ivc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_inversions    (out_bus.inversions),
  .out_element_count (out_bus.element_count),
  .out_overflow      (out_bus.overflow)
);
`default_nettype wire
